@@ rtl/core/sha1tc_pkg.sv @@
// Shared types, constants and helper functions for the SHA-1 target compare block.
`timescale 1ns / 1ps

package sha1tc_pkg;

  localparam int WordW     = 32;
  localparam int BlockLen  = 16;
  localparam int IdxW      = 4;
  localparam int Rounds    = 80;
  localparam int RcntW     = 7;
  localparam int CfgIdxW   = 3;

  localparam logic [IdxW-1:0]  LastWordIdx = IdxW'(BlockLen - 1);
  localparam logic [RcntW-1:0] LastRound   = RcntW'(Rounds - 1);
  localparam logic [RcntW-1:0] Phase1Start = RcntW'(20);
  localparam logic [RcntW-1:0] Phase2Start = RcntW'(40);
  localparam logic [RcntW-1:0] Phase3Start = RcntW'(60);

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] RegTargetA = 3'd0;
  localparam logic [CfgIdxW-1:0] RegTargetB = 3'd1;
  localparam logic [CfgIdxW-1:0] RegTargetC = 3'd2;
  localparam logic [CfgIdxW-1:0] RegTargetD = 3'd3;
  localparam logic [CfgIdxW-1:0] RegTargetE = 3'd4;

  // Initial chaining values H0..H4.
  localparam logic [WordW-1:0] InitA = 32'h67452301;
  localparam logic [WordW-1:0] InitB = 32'hEFCDAB89;
  localparam logic [WordW-1:0] InitC = 32'h98BADCFE;
  localparam logic [WordW-1:0] InitD = 32'h10325476;
  localparam logic [WordW-1:0] InitE = 32'hC3D2E1F0;

  localparam logic [WordW-1:0] K0 = 32'h5A827999;
  localparam logic [WordW-1:0] K1 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K2 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K3 = 32'hCA62C1D6;

  typedef enum logic [1:0] {
    PH_CH,
    PH_PAR1,
    PH_MAJ,
    PH_PAR2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic   load_word;
    logic   load_work;
    logic   round_en;
    phase_t phase;
    logic   add_chain;
    logic   emit_hash;
    logic   emit_err;
  } cmd_t;

  function automatic logic [WordW-1:0] rotl1(input logic [WordW-1:0] v);
    rotl1 = {v[WordW-2:0], v[WordW-1]};
  endfunction

  function automatic logic [WordW-1:0] rotl5(input logic [WordW-1:0] v);
    rotl5 = {v[WordW-6:0], v[WordW-1:WordW-5]};
  endfunction

  function automatic logic [WordW-1:0] rotl30(input logic [WordW-1:0] v);
    rotl30 = {v[1:0], v[WordW-1:2]};
  endfunction

  function automatic logic [WordW-1:0] round_k(input phase_t ph);
    logic [WordW-1:0] k;
    unique case (ph)
      PH_CH:   k = K0;
      PH_PAR1: k = K1;
      PH_MAJ:  k = K2;
      PH_PAR2: k = K3;
      default: k = K0;
    endcase
    round_k = k;
  endfunction

  function automatic logic [WordW-1:0] round_f(input phase_t ph,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    logic [WordW-1:0] f;
    unique case (ph)
      PH_CH:               f = (b & c) | (~b & d);
      PH_MAJ:              f = (b & c) | (b & d) | (c & d);
      PH_PAR1, PH_PAR2:    f = b ^ c ^ d;
      default:             f = b ^ c ^ d;
    endcase
    round_f = f;
  endfunction

endpackage

@@ rtl/core/sha1tc_ifs.sv @@
// Valid/ready channel interfaces for message words and digest results.
`timescale 1ns / 1ps

interface sha1tc_msg_if;
  logic        valid;
  logic        ready;
  logic [31:0] msg_word;
  logic        msg_end;

  modport source (output valid, output msg_word, output msg_end, input ready);
  modport sink   (input valid, input msg_word, input msg_end, output ready);
endinterface

interface sha1tc_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_a;
  logic [31:0] hash_b;
  logic [31:0] hash_c;
  logic [31:0] hash_d;
  logic [31:0] hash_e;
  logic        is_match;
  logic        misaligned;

  modport source (output valid, output hash_a, output hash_b, output hash_c,
                  output hash_d, output hash_e, output is_match, output misaligned,
                  input ready);
  modport sink   (input valid, input hash_a, input hash_b, input hash_c,
                  input hash_d, input hash_e, input is_match, input misaligned,
                  output ready);
endinterface

@@ rtl/core/sha1_hash_with_target_compare.sv @@
// Top level of the SHA-1 digest engine with target digest compare.
//
// msg_in carries one big-endian word of an already padded message per beat,
// with msg_end set on the final word. Every sixteen words form a block that
// one round unit compresses at one round per cycle, after which an add step
// folds the result into the chaining words. Words are not taken while a
// block is being compressed.
// digest_out delivers one beat per message: the digest, is_match when it
// equals the five target registers, and misaligned (with zero digest) when
// the end mark did not fall on a block's sixteenth word. An aligned end gives
// its result after the last round, through the ADD and then the EMIT state;
// a misaligned end raises valid at the edge that takes the beat. The result
// sits in an output register, and no word is taken while it waits, so a
// stalled receiver holds off the input until the beat is taken.
// Targets are written through cfg_we/cfg_index/cfg_data; the user must do
// so only while idle, as the block itself does not enforce it.
// Reset (synchronous, rst high) clears targets to zero, loads the initial
// chaining values and drops any partial block.
`timescale 1ns / 1ps

module sha1_hash_with_target_compare (
  input  logic                                  clk,
  input  logic                                  rst,
  sha1tc_msg_if.sink                            msg_in,
  sha1tc_dig_if.source                          digest_out,
  input  logic                                  cfg_we,
  input  logic [sha1tc_pkg::CfgIdxW-1:0]        cfg_index,
  input  logic [sha1tc_pkg::WordW-1:0]          cfg_data
);

  sha1tc_pkg::cmd_t cmd;
  logic             in_ready;
  logic             out_valid;

  assign msg_in.ready     = in_ready;
  assign digest_out.valid = out_valid;

  sha1tc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg_in.valid),
    .msg_end   (msg_in.msg_end),
    .in_ready  (in_ready),
    .out_ready (digest_out.ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  sha1tc_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .msg_word   (msg_in.msg_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .hash_a     (digest_out.hash_a),
    .hash_b     (digest_out.hash_b),
    .hash_c     (digest_out.hash_c),
    .hash_d     (digest_out.hash_d),
    .hash_e     (digest_out.hash_e),
    .is_match   (digest_out.is_match),
    .misaligned (digest_out.misaligned)
  );

endmodule

@@ rtl/core/sha1tc_ctrl.sv @@
// Controller: word counting, round sequencing and output handshake.
`timescale 1ns / 1ps

module sha1tc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                msg_end,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  output sha1tc_pkg::cmd_t    cmd
);

  sha1tc_pkg::state_t                   state;
  sha1tc_pkg::state_t                   state_next;
  logic [sha1tc_pkg::IdxW-1:0]          word_index;
  logic [sha1tc_pkg::RcntW-1:0]         round_cnt;
  logic                                 pend_last;
  logic                                 slot_free;
  logic                                 accept;
  logic                                 block_full;

  assign slot_free  = !out_valid || out_ready;
  assign in_ready   = (state == sha1tc_pkg::ST_IDLE) && slot_free;
  assign accept     = in_valid && in_ready;
  assign block_full = (word_index == sha1tc_pkg::LastWordIdx);

  always_comb begin
    state_next = state;
    unique case (state)
      sha1tc_pkg::ST_IDLE: begin
        if (accept && block_full) state_next = sha1tc_pkg::ST_ROUND;
      end
      sha1tc_pkg::ST_ROUND: begin
        if (round_cnt == sha1tc_pkg::LastRound) state_next = sha1tc_pkg::ST_ADD;
      end
      sha1tc_pkg::ST_ADD: begin
        state_next = pend_last ? sha1tc_pkg::ST_EMIT : sha1tc_pkg::ST_IDLE;
      end
      sha1tc_pkg::ST_EMIT: begin
        if (slot_free) state_next = sha1tc_pkg::ST_IDLE;
      end
      default: state_next = sha1tc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.phase = sha1tc_pkg::PH_CH;
    unique case (state)
      sha1tc_pkg::ST_IDLE: begin
        cmd.load_word = accept;
        cmd.load_work = accept && block_full;
        cmd.emit_err  = accept && msg_end && !block_full;
      end
      sha1tc_pkg::ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (round_cnt < sha1tc_pkg::Phase1Start)      cmd.phase = sha1tc_pkg::PH_CH;
        else if (round_cnt < sha1tc_pkg::Phase2Start) cmd.phase = sha1tc_pkg::PH_PAR1;
        else if (round_cnt < sha1tc_pkg::Phase3Start) cmd.phase = sha1tc_pkg::PH_MAJ;
        else                                          cmd.phase = sha1tc_pkg::PH_PAR2;
      end
      sha1tc_pkg::ST_ADD: begin
        cmd.add_chain = 1'b1;
      end
      sha1tc_pkg::ST_EMIT: begin
        cmd.emit_hash = slot_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha1tc_pkg::ST_IDLE;
      word_index <= '0;
      round_cnt  <= '0;
      pend_last  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;

      // A misaligned end mark drops the partial block and starts over.
      if (cmd.emit_err) word_index <= '0;
      else if (cmd.load_word) word_index <= word_index + 1'b1;

      if (state == sha1tc_pkg::ST_ROUND) round_cnt <= round_cnt + 1'b1;
      else round_cnt <= '0;

      if (cmd.load_work) pend_last <= msg_end;

      if (cmd.emit_hash || cmd.emit_err) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_round_to_add: assert property (@(posedge clk) disable iff (rst)
    (state == sha1tc_pkg::ST_ROUND && round_cnt == sha1tc_pkg::LastRound)
      |=> state == sha1tc_pkg::ST_ADD)
    else $error("compression did not finish after the last round");

  a_block_starts_rounds: assert property (@(posedge clk) disable iff (rst)
    (accept && block_full) |=> (state == sha1tc_pkg::ST_ROUND && round_cnt == '0))
    else $error("full block did not start compression at round zero");

  a_emit_only_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_hash || cmd.emit_err) |-> (!out_valid || out_ready))
    else $error("result loaded over a beat that was not taken");

  a_index_clear_after_end: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_hash || cmd.emit_err) |=> (word_index == '0 && out_valid))
    else $error("word index not cleared after end of message");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != sha1tc_pkg::ST_IDLE) |-> !cmd.load_word)
    else $error("word accepted during compression");

endmodule

@@ rtl/core/sha1tc_dp.sv @@
// Datapath: schedule window, round unit, chaining words, targets and result register.
`timescale 1ns / 1ps

module sha1tc_dp (
  input  logic                                         clk,
  input  logic                                         rst,
  input  sha1tc_pkg::cmd_t                             cmd,
  input  logic [sha1tc_pkg::WordW-1:0]                 msg_word,
  input  logic                                         cfg_we,
  input  logic [sha1tc_pkg::CfgIdxW-1:0]               cfg_index,
  input  logic [sha1tc_pkg::WordW-1:0]                 cfg_data,
  output logic [sha1tc_pkg::WordW-1:0]                 hash_a,
  output logic [sha1tc_pkg::WordW-1:0]                 hash_b,
  output logic [sha1tc_pkg::WordW-1:0]                 hash_c,
  output logic [sha1tc_pkg::WordW-1:0]                 hash_d,
  output logic [sha1tc_pkg::WordW-1:0]                 hash_e,
  output logic                                         is_match,
  output logic                                         misaligned
);

  logic [sha1tc_pkg::WordW-1:0] win [sha1tc_pkg::BlockLen];
  logic [sha1tc_pkg::WordW-1:0] sched_new;
  logic [sha1tc_pkg::WordW-1:0] wa, wb, wc, wd, we;
  logic [sha1tc_pkg::WordW-1:0] ha, hb, hc, hd, he;
  logic [sha1tc_pkg::WordW-1:0] tgt_a, tgt_b, tgt_c, tgt_d, tgt_e;
  logic [sha1tc_pkg::WordW-1:0] t_sum;
  logic                         match_now;

  // The window holds W[r] .. W[r+15]; each round pulls the next schedule word in.
  assign sched_new = sha1tc_pkg::rotl1(win[13] ^ win[8] ^ win[2] ^ win[0]);

  assign t_sum = sha1tc_pkg::rotl5(wa) + sha1tc_pkg::round_f(cmd.phase, wb, wc, wd)
               + we + win[0] + sha1tc_pkg::round_k(cmd.phase);

  assign match_now = (ha == tgt_a) && (hb == tgt_b) && (hc == tgt_c)
                  && (hd == tgt_d) && (he == tgt_e);

  always_ff @(posedge clk) begin
    if (cmd.load_word || cmd.round_en) begin
      for (int i = 0; i < sha1tc_pkg::BlockLen - 1; i++) begin
        win[i] <= win[i+1];
      end
      win[sha1tc_pkg::BlockLen-1] <= cmd.load_word ? msg_word : sched_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_work) begin
      wa <= ha;
      wb <= hb;
      wc <= hc;
      wd <= hd;
      we <= he;
    end else if (cmd.round_en) begin
      wa <= t_sum;
      wb <= wa;
      wc <= sha1tc_pkg::rotl30(wb);
      wd <= wc;
      we <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.emit_hash || cmd.emit_err) begin
      ha <= sha1tc_pkg::InitA;
      hb <= sha1tc_pkg::InitB;
      hc <= sha1tc_pkg::InitC;
      hd <= sha1tc_pkg::InitD;
      he <= sha1tc_pkg::InitE;
    end else if (cmd.add_chain) begin
      ha <= ha + wa;
      hb <= hb + wb;
      hc <= hc + wc;
      hd <= hd + wd;
      he <= he + we;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tgt_a <= '0;
      tgt_b <= '0;
      tgt_c <= '0;
      tgt_d <= '0;
      tgt_e <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sha1tc_pkg::RegTargetA: tgt_a <= cfg_data;
        sha1tc_pkg::RegTargetB: tgt_b <= cfg_data;
        sha1tc_pkg::RegTargetC: tgt_c <= cfg_data;
        sha1tc_pkg::RegTargetD: tgt_d <= cfg_data;
        sha1tc_pkg::RegTargetE: tgt_e <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hash) begin
      hash_a     <= ha;
      hash_b     <= hb;
      hash_c     <= hc;
      hash_d     <= hd;
      hash_e     <= he;
      is_match   <= match_now;
      misaligned <= 1'b0;
    end else if (cmd.emit_err) begin
      hash_a     <= '0;
      hash_b     <= '0;
      hash_c     <= '0;
      hash_d     <= '0;
      hash_e     <= '0;
      is_match   <= 1'b0;
      misaligned <= 1'b1;
    end
  end

endmodule

@@ test/tb_sha1_hash_with_target_compare.sv @@
// Self-checking testbench for the SHA-1 digest engine with target compare.
`timescale 1ns / 1ps

module tb_sha1_hash_with_target_compare;
  import sha1tc_pkg::*;

  typedef logic [4:0][WordW-1:0]  chain_t;
  typedef logic [15:0][WordW-1:0] block_t;
  typedef logic [WordW-1:0]       word_q_t[$];

  typedef struct packed {
    logic [WordW-1:0] hash_a;
    logic [WordW-1:0] hash_b;
    logic [WordW-1:0] hash_c;
    logic [WordW-1:0] hash_d;
    logic [WordW-1:0] hash_e;
    logic             is_match;
    logic             misaligned;
  } digest_t;

  localparam chain_t InitChain    = {InitE, InitD, InitC, InitB, InitA};
  localparam int     MsgItems     = 750;
  localparam int     SettleCycles = 120;
  localparam int     CycleLimit   = 200000;
  localparam logic [CfgIdxW-1:0] TargetRegs [5] = '{RegTargetA, RegTargetB, RegTargetC,
                                                    RegTargetD, RegTargetE};

  class digest_scoreboard;
    logic [WordW-1:0] target [5];
    chain_t           chain;
    block_t           blk;
    int unsigned      fill;
    digest_t          expected_digests[$];
    string            field_names [7];
    int               errors;
    int               words_seen;
    int               aligned_seen;
    int               misaligned_seen;
    int               matches_seen;

    function new();
      foreach (target[i]) target[i] = '0;
      chain = InitChain;
      blk = '0;
      fill = 0;
      errors = 0;
      words_seen = 0;
      aligned_seen = 0;
      misaligned_seen = 0;
      matches_seen = 0;
      field_names = '{"hash_a", "hash_b", "hash_c", "hash_d", "hash_e",
                      "is_match", "misaligned"};
    endfunction

    static function logic [WordW-1:0] rol(logic [WordW-1:0] v, int unsigned n);
      return (v << n) | (v >> (WordW - n));
    endfunction

    static function chain_t sha1_compress(chain_t h, block_t m);
      logic [WordW-1:0] w [80];
      logic [WordW-1:0] a, b, c, d, e, f, k, t;
      int r;
      for (r = 0; r < 16; r++) w[r] = m[r];
      for (r = 16; r < 80; r++) w[r] = rol(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
      a = h[0];
      b = h[1];
      c = h[2];
      d = h[3];
      e = h[4];
      for (r = 0; r < 80; r++) begin
        if (r < 20) begin
          f = (b & c) | (~b & d);
          k = K0;
        end else if (r < 40) begin
          f = b ^ c ^ d;
          k = K1;
        end else if (r < 60) begin
          f = (b & c) | (b & d) | (c & d);
          k = K2;
        end else begin
          f = b ^ c ^ d;
          k = K3;
        end
        t = rol(a, 5) + f + e + w[r] + k;
        e = d;
        d = c;
        c = rol(b, 30);
        b = a;
        a = t;
      end
      h[0] = h[0] + a;
      h[1] = h[1] + b;
      h[2] = h[2] + c;
      h[3] = h[3] + d;
      h[4] = h[4] + e;
      return h;
    endfunction

    // Digest of a whole message whose length is a multiple of sixteen words.
    function chain_t digest_of(word_q_t words);
      chain_t h;
      block_t b;
      h = InitChain;
      b = '0;
      foreach (words[i]) begin
        b[i % 16] = words[i];
        if (i % 16 == 15) h = sha1_compress(h, b);
      end
      return h;
    endfunction

    function void set_target(int i, logic [WordW-1:0] v);
      target[i] = v;
    endfunction

    function void note_word(logic [WordW-1:0] w, logic last);
      digest_t d;
      logic full;
      words_seen++;
      blk[fill] = w;
      full = (fill == 15);
      fill = (fill + 1) % 16;
      if (full) chain = sha1_compress(chain, blk);
      if (!last) return;
      d = '0;
      if (full) begin
        d.hash_a = chain[0];
        d.hash_b = chain[1];
        d.hash_c = chain[2];
        d.hash_d = chain[3];
        d.hash_e = chain[4];
        d.is_match = (chain[0] == target[0]) && (chain[1] == target[1]) &&
                     (chain[2] == target[2]) && (chain[3] == target[3]) &&
                     (chain[4] == target[4]);
      end else begin
        // A partial block is thrown away and only the error flag is raised.
        d.misaligned = 1'b1;
      end
      expected_digests.push_back(d);
      chain = InitChain;
      fill = 0;
    endfunction

    static function logic [WordW-1:0] field_value(digest_t d, int i);
      case (i)
        0:       return d.hash_a;
        1:       return d.hash_b;
        2:       return d.hash_c;
        3:       return d.hash_d;
        4:       return d.hash_e;
        5:       return {{(WordW-1){1'b0}}, d.is_match};
        default: return {{(WordW-1){1'b0}}, d.misaligned};
      endcase
    endfunction

    function void check_digest(digest_t got);
      digest_t want;
      if (expected_digests.size() == 0) begin
        $error("digest beat arrived with no digest pending");
        errors++;
        return;
      end
      want = expected_digests.pop_front();
      if (want.misaligned) misaligned_seen++;
      else aligned_seen++;
      if (want.is_match) matches_seen++;
      for (int i = 0; i < 7; i++) begin
        if (field_value(want, i) !== field_value(got, i)) begin
          $error("%s mismatch: expected %h, actual %h", field_names[i],
                 field_value(want, i), field_value(got, i));
          errors++;
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [WordW-1:0]     cfg_data;
  bit                   src_calm;
  bit                   sink_calm;

  sha1tc_msg_if msg_bus ();
  sha1tc_dig_if dig_bus ();

  digest_scoreboard sb = new();

  always #1 clk = ~clk;

  sha1_hash_with_target_compare dut (
    .clk        (clk),
    .rst        (rst),
    .msg_in     (msg_bus),
    .digest_out (dig_bus),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always @(posedge clk) begin
    if (!rst && msg_bus.valid && msg_bus.ready) begin
      sb.note_word(msg_bus.msg_word, msg_bus.msg_end);
    end
  end

  // Digest side: each waiting beat is held off for a random number of cycles
  // unless the sink is in a no-stall stretch.
  initial begin : digest_sink
    int unsigned hold;
    bit armed;
    hold = 0;
    armed = 1'b0;
    dig_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && dig_bus.valid && dig_bus.ready) begin
        sb.check_digest({dig_bus.hash_a, dig_bus.hash_b, dig_bus.hash_c, dig_bus.hash_d,
                         dig_bus.hash_e, dig_bus.is_match, dig_bus.misaligned});
        armed = 1'b0;
      end else if (!rst && dig_bus.valid && !armed) begin
        hold = $urandom_range(0, 11);
        armed = 1'b1;
      end else if (hold > 0) begin
        hold--;
      end
      dig_bus.ready <= !rst && (sink_calm || (armed && hold == 0));
    end
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [WordW-1:0] pick_word();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic send_word(input logic [WordW-1:0] w, input logic last);
    int unsigned gap;
    gap = src_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      msg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg_bus.valid <= 1'b1;
    msg_bus.msg_word <= w;
    msg_bus.msg_end <= last;
    do @(posedge clk); while (!msg_bus.ready);
  endtask

  task automatic send_message(input word_q_t words);
    foreach (words[i]) send_word(words[i], i == words.size() - 1);
  endtask

  // Stop sending, wait for every pending digest and let a block still in
  // compression finish before the targets may change.
  task automatic settle();
    msg_bus.valid <= 1'b0;
    while (sb.expected_digests.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_targets(input chain_t t);
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= TargetRegs[i];
      cfg_data <= t[i];
      sb.set_target(i, t[i]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    word_q_t words;
    chain_t tgt;
    int sent;
    int msgs;
    int phase;
    int mode;
    int len;
    bit aligned;

    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= RegTargetA;
    cfg_data <= '0;
    msg_bus.valid <= 1'b0;
    msg_bus.msg_word <= '0;
    msg_bus.msg_end <= 1'b0;
    src_calm = 1'b0;
    sink_calm = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A lone end mark is misaligned, even though its zero digest equals the
    // zero targets left by reset.
    words.delete();
    words.push_back('0);
    send_message(words);

    // One aligned block of extreme words, with its own digest as target.
    words.delete();
    words.push_back('0);
    repeat (14) words.push_back('1);
    words.push_back('0);
    settle();
    write_targets(sb.digest_of(words));
    send_message(words);

    // End mark in the middle of a block.
    words.delete();
    words.push_back('1);
    words.push_back('0);
    repeat (3) words.push_back($urandom);
    send_message(words);

    sent = 0;
    msgs = 0;
    phase = 0;
    while (sent < MsgItems) begin
      aligned = ($urandom_range(0, 9) < 7);
      mode = -1;
      if (msgs % 6 == 0) begin
        mode = phase % 5;
        phase++;
        if (mode == 2 || mode == 3) aligned = 1'b1;
      end
      if (aligned) begin
        len = ($urandom_range(0, 5) == 0) ? 16 * $urandom_range(2, 3) : 16;
      end else begin
        len = $urandom_range(1, 40);
        if (len % 16 == 0) len++;
      end
      words.delete();
      repeat (len) words.push_back(pick_word());

      if (mode >= 0) begin
        settle();
        case (mode)
          0: tgt = '1;
          1: for (int i = 0; i < 5; i++) tgt[i] = $urandom;
          2: tgt = sb.digest_of(words);
          3: begin
            // One bit off the true digest must not count as a hit.
            tgt = sb.digest_of(words);
            tgt[$urandom_range(0, 4)][$urandom_range(0, WordW - 1)] ^= 1'b1;
          end
          default: tgt = '0;
        endcase
        write_targets(tgt);
      end

      src_calm = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);
      send_message(words);
      sent += len;
      msgs++;
    end

    src_calm = 1'b0;
    sink_calm = 1'b0;
    settle();

    $display("Sent %0d message words: %0d aligned digests (%0d on target), %0d misaligned ends.",
             sb.words_seen, sb.aligned_seen, sb.matches_seen, sb.misaligned_seen);
    $display("Targets went through zero, all-ones, random, exact and near-miss settings.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
